@@ rtl/core/arm2r_dynamics_terms_top_macros.svh @@
`ifndef ARM2R_DYNAMICS_TERMS_TOP_MACROS_SVH
`define ARM2R_DYNAMICS_TERMS_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and quiet during reset.
`define A2RDYN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and quiet during reset.
`define A2RDYN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/a2rdyn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package a2rdyn_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_ADDR_BITS = 10;
  localparam int TRIG_N         = 1 << TRIG_ADDR_BITS;
  localparam int TRIG_HALF      = TRIG_N / 2;
  localparam int FRAC_BITS      = ANGLE_BITS - 2;
  localparam int TRIG_W         = 17;
  localparam int TRIG_SW        = 18;

  localparam int ANGLE_W   = 16;
  localparam int RATE_W    = 20;
  localparam int DQ_W      = 24;
  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 48;
  localparam int PW        = 80;
  localparam int Q_FRAC    = 16;
  localparam int KSPLIT    = 21;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam logic [REG_W-1:0]        RST_M1  = 24'd65536;
  localparam logic [REG_W-1:0]        RST_M2  = 24'd65536;
  localparam logic [REG_W-1:0]        RST_L1  = 24'd65536;
  localparam logic [REG_W-1:0]        RST_LC1 = 24'd32768;
  localparam logic [REG_W-1:0]        RST_LC2 = 24'd32768;
  localparam logic [REG_W-1:0]        RST_I1  = 24'd0;
  localparam logic [REG_W-1:0]        RST_I2  = 24'd0;
  localparam logic signed [REG_W-1:0] RST_G0  = 24'sd642908;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS1   = 3'd0,
    REG_MASS2   = 3'd1,
    REG_LEN1    = 3'd2,
    REG_COM1    = 3'd3,
    REG_COM2    = 3'd4,
    REG_INERT1  = 3'd5,
    REG_INERT2  = 3'd6,
    REG_GRAVITY = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0]        m1;
    logic [REG_W-1:0]        m2;
    logic [REG_W-1:0]        l1;
    logic [REG_W-1:0]        lc1;
    logic [REG_W-1:0]        lc2;
    logic [REG_W-1:0]        i1;
    logic [REG_W-1:0]        i2;
    logic signed [REG_W-1:0] g0;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_SW-1:0] s2;
    logic signed [TRIG_SW-1:0] c2;
    logic signed [TRIG_SW-1:0] c1;
    logic signed [TRIG_SW-1:0] c12;
  } trig_t;

  typedef struct packed {
    logic                    neg;
    logic [TRIG_ADDR_BITS:0] addr;
  } trig_addr_t;

  typedef logic [TRIG_W-1:0] sine_entry_t;
  typedef logic [TRIG_N:0][TRIG_W-1:0] sine_tab_t;

  // Quarter-wave sine in Q1.16, built from a Q30 Taylor series through x^11.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    int              k;
    for (k = 0; k <= TRIG_N; k++) begin
      x  = (HALF_PI_Q30 * longint'(k) + longint'(TRIG_HALF)) >> TRIG_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s = (x * t) >> 30;
      tab[k] = TRIG_W'((s + 64'h2000) >> 14);
    end
    return tab;
  endfunction

  // Quadrant folding: odd quadrants mirror the address, the upper half negates.
  function automatic trig_addr_t sine_addr(input logic [ANGLE_BITS-1:0] a);
    trig_addr_t                              r;
    logic [1:0]                              quad;
    logic [FRAC_BITS+TRIG_ADDR_BITS-1:0]     scaled;
    logic [TRIG_ADDR_BITS:0]                 idx;
    quad   = a[ANGLE_BITS-1 -: 2];
    scaled = {a[FRAC_BITS-1:0], {TRIG_ADDR_BITS{1'b0}}} >> FRAC_BITS;
    idx    = {1'b0, scaled[TRIG_ADDR_BITS-1:0]};
    r.neg  = quad[1];
    r.addr = quad[0] ? ((TRIG_ADDR_BITS + 1)'(TRIG_N) - idx) : idx;
    return r;
  endfunction

  function automatic logic signed [TRIG_SW-1:0] signed_entry(input sine_entry_t e,
                                                             input logic neg);
    logic signed [TRIG_SW-1:0] v;
    v = $signed({1'b0, e});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [PW-1:0] uext(input logic [REG_W-1:0] v);
    return PW'($signed({1'b0, v}));
  endfunction

  // Drop 16 fraction bits, rounding half away from zero.
  function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] bias;
    bias = $signed({{(PW - Q_FRAC){1'b0}}, ~p[PW-1], {(Q_FRAC - 1){p[PW-1]}}});
    return (p + bias) >>> Q_FRAC;
  endfunction

  function automatic logic signed [PW-1:0] mulr(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    return rnd16(p);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/arm2r_dynamics_terms_top.sv @@
// Two-link planar arm dynamics: inertia matrix, Coriolis and gravity torques.
// Input channel (in_valid/in_ready) carries one beat per evaluation: the two
// joint angles in binary angle units and the two joint rates in Q8.12.
// Output channel (out_valid/out_ready) returns one beat per input beat, in
// order, with M11, M12, M22, both Coriolis torques, both gravity torques in
// Q32.16 and an overflow flag that is set when a Coriolis torque clamped.
// Link parameters are written through cfg_we/cfg_idx/cfg_wdata, one register
// per cycle; the user must write them only while the pipeline is empty, as
// the block does not enforce it. There are 6 register stages; out_valid
// rises once an accepted beat reaches the last of them. Throughput is one
// beat per cycle unless out_ready stalls the pipeline. The depth is set by
// the chained multiplies: the sine lookup, the config products, the widest
// Coriolis product split over two stages, and the final rounding and clamp.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the default link parameters; the sine
// table is a constant ROM and needs no fill.
`timescale 1ns / 1ps
`default_nettype none

module arm2r_dynamics_terms_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [a2rdyn_pkg::ANGLE_W-1:0]       in_shoulder_angle,
  input  logic [a2rdyn_pkg::ANGLE_W-1:0]       in_elbow_angle,
  input  logic signed [a2rdyn_pkg::RATE_W-1:0] in_shoulder_rate,
  input  logic signed [a2rdyn_pkg::RATE_W-1:0] in_elbow_rate,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_inertia_11,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_inertia_12,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_inertia_22,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_coriolis_1,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_coriolis_2,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_gravity_1,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  out_gravity_2,
  output logic                                 out_overflow,
  input  logic                                 cfg_we,
  input  logic [a2rdyn_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [a2rdyn_pkg::REG_W-1:0]         cfg_wdata
);
  import a2rdyn_pkg::*;

  cfg_t  cfg;
  trig_t trig;
  logic  adv;

  a2rdyn_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  a2rdyn_trig u_trig (
    .clk            (clk),
    .en             (adv),
    .shoulder_angle (in_shoulder_angle),
    .elbow_angle    (in_elbow_angle),
    .trig           (trig)
  );

  a2rdyn_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .trig          (trig),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .shoulder_rate (in_shoulder_rate),
    .elbow_rate    (in_elbow_rate),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .inertia_11    (out_inertia_11),
    .inertia_12    (out_inertia_12),
    .inertia_22    (out_inertia_22),
    .coriolis_1    (out_coriolis_1),
    .coriolis_2    (out_coriolis_2),
    .gravity_1     (out_gravity_1),
    .gravity_2     (out_gravity_2),
    .overflow      (out_overflow)
  );

endmodule

`default_nettype wire

@@ rtl/core/a2rdyn_sine_rom.sv @@
`timescale 1ns / 1ps
`default_nettype none

module a2rdyn_sine_rom (
  input  logic                                clk,
  input  logic                                en,
  input  logic [a2rdyn_pkg::TRIG_ADDR_BITS:0] addr_a,
  input  logic [a2rdyn_pkg::TRIG_ADDR_BITS:0] addr_b,
  output a2rdyn_pkg::sine_entry_t             data_a,
  output a2rdyn_pkg::sine_entry_t             data_b
);
  import a2rdyn_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  sine_entry_t data_a_r;
  sine_entry_t data_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= SINE_TAB[addr_a];
      data_b_r <= SINE_TAB[addr_b];
    end
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

`default_nettype wire

@@ rtl/core/a2rdyn_trig.sv @@
`timescale 1ns / 1ps
`default_nettype none

module a2rdyn_trig (
  input  logic                         clk,
  input  logic                         en,
  input  logic [a2rdyn_pkg::ANGLE_W-1:0] shoulder_angle,
  input  logic [a2rdyn_pkg::ANGLE_W-1:0] elbow_angle,
  output a2rdyn_pkg::trig_t            trig
);
  import a2rdyn_pkg::*;

  logic [ANGLE_BITS-1:0] a1;
  logic [ANGLE_BITS-1:0] a2;
  logic [ANGLE_BITS-1:0] a12;
  trig_addr_t            ad_s2;
  trig_addr_t            ad_c2;
  trig_addr_t            ad_c1;
  trig_addr_t            ad_c12;
  sine_entry_t           e_s2;
  sine_entry_t           e_c2;
  sine_entry_t           e_c1;
  sine_entry_t           e_c12;
  logic [3:0]            neg_r;

  assign a1  = ANGLE_BITS'(shoulder_angle);
  assign a2  = ANGLE_BITS'(elbow_angle);
  assign a12 = a1 + a2;

  // Cosine is the sine a quarter turn later.
  assign ad_s2  = sine_addr(a2);
  assign ad_c2  = sine_addr(a2 + QUARTER);
  assign ad_c1  = sine_addr(a1 + QUARTER);
  assign ad_c12 = sine_addr(a12 + QUARTER);

  a2rdyn_sine_rom u_rom_elbow (
    .clk    (clk),
    .en     (en),
    .addr_a (ad_s2.addr),
    .addr_b (ad_c2.addr),
    .data_a (e_s2),
    .data_b (e_c2)
  );

  a2rdyn_sine_rom u_rom_sum (
    .clk    (clk),
    .en     (en),
    .addr_a (ad_c1.addr),
    .addr_b (ad_c12.addr),
    .data_a (e_c1),
    .data_b (e_c12)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= {ad_c12.neg, ad_c1.neg, ad_c2.neg, ad_s2.neg};
    end
  end

  assign trig.s2  = signed_entry(e_s2, neg_r[0]);
  assign trig.c2  = signed_entry(e_c2, neg_r[1]);
  assign trig.c1  = signed_entry(e_c1, neg_r[2]);
  assign trig.c12 = signed_entry(e_c12, neg_r[3]);

endmodule

`default_nettype wire

@@ rtl/core/a2rdyn_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module a2rdyn_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [a2rdyn_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [a2rdyn_pkg::REG_W-1:0]     cfg_wdata,
  output a2rdyn_pkg::cfg_t                 cfg
);
  import a2rdyn_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.m1  <= RST_M1;
      cfg_r.m2  <= RST_M2;
      cfg_r.l1  <= RST_L1;
      cfg_r.lc1 <= RST_LC1;
      cfg_r.lc2 <= RST_LC2;
      cfg_r.i1  <= RST_I1;
      cfg_r.i2  <= RST_I2;
      cfg_r.g0  <= RST_G0;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_idx))
        REG_MASS1:   cfg_r.m1  <= cfg_wdata;
        REG_MASS2:   cfg_r.m2  <= cfg_wdata;
        REG_LEN1:    cfg_r.l1  <= cfg_wdata;
        REG_COM1:    cfg_r.lc1 <= cfg_wdata;
        REG_COM2:    cfg_r.lc2 <= cfg_wdata;
        REG_INERT1:  cfg_r.i1  <= cfg_wdata;
        REG_INERT2:  cfg_r.i2  <= cfg_wdata;
        REG_GRAVITY: cfg_r.g0  <= $signed(cfg_wdata);
        default:     cfg_r     <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/core/a2rdyn_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "arm2r_dynamics_terms_top_macros.svh"

module a2rdyn_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  a2rdyn_pkg::cfg_t                     cfg,
  input  a2rdyn_pkg::trig_t                    trig,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [a2rdyn_pkg::RATE_W-1:0] shoulder_rate,
  input  logic signed [a2rdyn_pkg::RATE_W-1:0] elbow_rate,
  output logic                                 adv,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  inertia_11,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  inertia_12,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  inertia_22,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  coriolis_1,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  coriolis_2,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  gravity_1,
  output logic signed [a2rdyn_pkg::OUT_W-1:0]  gravity_2,
  output logic                                 overflow
);
  import a2rdyn_pkg::*;

  localparam int NST = 6;
  localparam logic signed [PW-1:0] Q_MAX_W =
    $signed({{(PW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}});
  localparam logic signed [PW-1:0] Q_MIN_W =
    $signed({{(PW - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}});

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;

  // Stage 1: config products and rate products.
  logic signed [DQ_W-1:0] dq1;
  logic signed [DQ_W-1:0] dq2;
  logic signed [31:0] d11_nxt, d12_nxt, d22_nxt, d11_r, d12_r, d22_r;
  logic signed [32:0] lc2sq_nxt, l1lc2_nxt, l1sq_nxt, m1lc1_nxt, m2lc2_nxt, m2l1_nxt;
  logic signed [32:0] lc2sq_r, l1lc2_r, l1sq_r, m1lc1_r, m2lc2_r, m2l1_r;

  // Stage 2.
  logic signed [33:0] p_nxt, p_r, tg_nxt, tg_r, w_nxt, w_r;
  logic signed [40:0] mll_nxt, mll_r, kpre_nxt, kpre_r, g12a_nxt, g12a_r;
  logic signed [TRIG_SW-1:0] s2_2_r, c1_2_r, c12_2_r;
  logic signed [31:0] d11_2_r;
  logic signed [32:0] lc2sq_2_r, l1sq_2_r;

  // Stage 3.
  logic signed [35:0] t1_nxt, t1_r;
  logic signed [34:0] sp_nxt, sp_r;
  logic signed [41:0] k_nxt, k_r, gt_nxt, gt_r;
  logic signed [40:0] g12_nxt, g12_r, mll_3_r;
  logic signed [33:0] w_3_r;
  logic signed [31:0] d11_3_r;
  logic signed [32:0] lc2sq_3_r;
  logic signed [TRIG_SW-1:0] c1_3_r;

  // Stage 4.
  logic signed [KSPLIT:0]          kl;
  logic signed [41-KSPLIT:0]       kh;
  logic signed [43:0] m2t_nxt, m2t_r, m2sp_nxt, m2sp_r;
  logic signed [41:0] m2lc_nxt, m2lc_r, g1a_nxt, g1a_r, m11b_nxt, m11b_r;
  logic signed [55:0] kw_lo_nxt, kw_lo_r;
  logic signed [54:0] kw_hi_nxt, kw_hi_r;
  logic signed [53:0] kd_lo_nxt, kd_lo_r;
  logic signed [52:0] kd_hi_nxt, kd_hi_r;
  logic signed [40:0] g12_4_r;

  // Stage 5.
  logic signed [OUT_W-1:0] m11_nxt, m11_r, m12_nxt, m12_r, m22_nxt, m22_r;
  logic signed [OUT_W-1:0] g1_nxt, g1_r;
  logic signed [40:0]      g2_5_r;
  logic signed [75:0]      pw_nxt, pw_r, pd_nxt, pd_r;

  // Stage 6: output registers.
  logic signed [PW-1:0]    rw;
  logic signed [PW-1:0]    rd;
  logic signed [OUT_W-1:0] h1_nxt, h2_nxt;
  logic                    ovf_nxt;
  logic signed [OUT_W-1:0] out_m11_r, out_m12_r, out_m22_r, out_h1_r, out_h2_r;
  logic signed [OUT_W-1:0] out_g1_r, out_g2_r;
  logic                    ovf_r;

  // The whole pipeline moves together; a stall freezes every stage.
  assign adv      = !v_r[NST-1] || out_ready;
  assign in_ready = adv;
  assign v_nxt    = {v_r[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    dq1       = $signed({shoulder_rate, 4'b0000});
    dq2       = $signed({elbow_rate, 4'b0000});
    d11_nxt   = 32'(mulr(PW'(dq1), PW'(dq1)));
    d12_nxt   = 32'(mulr(PW'(dq1), PW'(dq2)));
    d22_nxt   = 32'(mulr(PW'(dq2), PW'(dq2)));
    lc2sq_nxt = 33'(mulr(uext(cfg.lc2), uext(cfg.lc2)));
    l1lc2_nxt = 33'(mulr(uext(cfg.l1), uext(cfg.lc2)));
    l1sq_nxt  = 33'(mulr(uext(cfg.l1), uext(cfg.l1)));
    m1lc1_nxt = 33'(mulr(uext(cfg.m1), uext(cfg.lc1)));
    m2lc2_nxt = 33'(mulr(uext(cfg.m2), uext(cfg.lc2)));
    m2l1_nxt  = 33'(mulr(uext(cfg.m2), uext(cfg.l1)));
  end

  always_comb begin
    p_nxt    = 34'(mulr(PW'(l1lc2_r), PW'(trig.c2)));
    mll_nxt  = 41'(mulr(PW'(m1lc1_r), uext(cfg.lc1)));
    kpre_nxt = 41'(mulr(uext(cfg.m2), PW'(l1lc2_r)));
    g12a_nxt = 41'(mulr(PW'(m2lc2_r), PW'(cfg.g0)));
    tg_nxt   = 34'(m1lc1_r) + 34'(m2l1_r);
    w_nxt    = (34'(d12_r) <<< 1) + 34'(d22_r);
  end

  always_comb begin
    t1_nxt  = 36'(l1sq_2_r) + 36'(lc2sq_2_r) + (36'(p_r) <<< 1);
    sp_nxt  = 35'(lc2sq_2_r) + 35'(p_r);
    k_nxt   = 42'(mulr(PW'(kpre_r), PW'(s2_2_r)));
    g12_nxt = 41'(mulr(PW'(g12a_r), PW'(c12_2_r)));
    gt_nxt  = 42'(mulr(PW'(tg_r), PW'(cfg.g0)));
  end

  // The Coriolis products are too wide for one multiplier, so k is split
  // into a signed upper half and an unsigned lower half.
  always_comb begin
    kl        = $signed({1'b0, k_r[KSPLIT-1:0]});
    kh        = $signed(k_r[41:KSPLIT]);
    m2t_nxt   = 44'(mulr(uext(cfg.m2), PW'(t1_r)));
    m2sp_nxt  = 44'(mulr(uext(cfg.m2), PW'(sp_r)));
    m2lc_nxt  = 42'(mulr(uext(cfg.m2), PW'(lc2sq_3_r)));
    g1a_nxt   = 42'(mulr(PW'(gt_r), PW'(c1_3_r)));
    m11b_nxt  = 42'(uext(cfg.i1)) + 42'(uext(cfg.i2)) + 42'(mll_3_r);
    kw_lo_nxt = kl * w_3_r;
    kw_hi_nxt = kh * w_3_r;
    kd_lo_nxt = kl * d11_3_r;
    kd_hi_nxt = kh * d11_3_r;
  end

  always_comb begin
    m11_nxt = 48'(m11b_r) + 48'(m2t_r);
    m12_nxt = 48'(uext(cfg.i2)) + 48'(m2sp_r);
    m22_nxt = 48'(uext(cfg.i2)) + 48'(m2lc_r);
    g1_nxt  = 48'(g1a_r) + 48'(g12_4_r);
    pw_nxt  = (76'(kw_hi_r) <<< KSPLIT) + 76'(kw_lo_r);
    pd_nxt  = (76'(kd_hi_r) <<< KSPLIT) + 76'(kd_lo_r);
  end

  // Only the Coriolis terms can leave the output range. The first one is
  // negated after its own clamp, so a clamp to the minimum clamps again.
  always_comb begin
    rw      = rnd16(PW'(pw_r));
    rd      = rnd16(PW'(pd_r));
    ovf_nxt = 1'b0;
    if (rw > Q_MAX_W) begin
      h1_nxt  = OUT_W'(-Q_MAX_W);
      ovf_nxt = 1'b1;
    end else if (rw <= Q_MIN_W) begin
      h1_nxt  = OUT_W'(Q_MAX_W);
      ovf_nxt = 1'b1;
    end else begin
      h1_nxt = OUT_W'(-rw);
    end
    if (rd > Q_MAX_W) begin
      h2_nxt  = OUT_W'(Q_MAX_W);
      ovf_nxt = 1'b1;
    end else if (rd < Q_MIN_W) begin
      h2_nxt  = OUT_W'(Q_MIN_W);
      ovf_nxt = 1'b1;
    end else begin
      h2_nxt = OUT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d11_r     <= d11_nxt;
      d12_r     <= d12_nxt;
      d22_r     <= d22_nxt;
      lc2sq_r   <= lc2sq_nxt;
      l1lc2_r   <= l1lc2_nxt;
      l1sq_r    <= l1sq_nxt;
      m1lc1_r   <= m1lc1_nxt;
      m2lc2_r   <= m2lc2_nxt;
      m2l1_r    <= m2l1_nxt;

      p_r       <= p_nxt;
      mll_r     <= mll_nxt;
      kpre_r    <= kpre_nxt;
      g12a_r    <= g12a_nxt;
      tg_r      <= tg_nxt;
      w_r       <= w_nxt;
      s2_2_r    <= trig.s2;
      c1_2_r    <= trig.c1;
      c12_2_r   <= trig.c12;
      d11_2_r   <= d11_r;
      lc2sq_2_r <= lc2sq_r;
      l1sq_2_r  <= l1sq_r;

      t1_r      <= t1_nxt;
      sp_r      <= sp_nxt;
      k_r       <= k_nxt;
      g12_r     <= g12_nxt;
      gt_r      <= gt_nxt;
      w_3_r     <= w_r;
      d11_3_r   <= d11_2_r;
      lc2sq_3_r <= lc2sq_2_r;
      mll_3_r   <= mll_r;
      c1_3_r    <= c1_2_r;

      m2t_r     <= m2t_nxt;
      m2sp_r    <= m2sp_nxt;
      m2lc_r    <= m2lc_nxt;
      g1a_r     <= g1a_nxt;
      m11b_r    <= m11b_nxt;
      kw_lo_r   <= kw_lo_nxt;
      kw_hi_r   <= kw_hi_nxt;
      kd_lo_r   <= kd_lo_nxt;
      kd_hi_r   <= kd_hi_nxt;
      g12_4_r   <= g12_r;

      m11_r     <= m11_nxt;
      m12_r     <= m12_nxt;
      m22_r     <= m22_nxt;
      g1_r      <= g1_nxt;
      g2_5_r    <= g12_4_r;
      pw_r      <= pw_nxt;
      pd_r      <= pd_nxt;

      out_m11_r <= m11_r;
      out_m12_r <= m12_r;
      out_m22_r <= m22_r;
      out_g1_r  <= g1_r;
      out_g2_r  <= 48'(g2_5_r);
      out_h1_r  <= h1_nxt;
      out_h2_r  <= h2_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  assign out_valid  = v_r[NST-1];
  assign inertia_11 = out_m11_r;
  assign inertia_12 = out_m12_r;
  assign inertia_22 = out_m22_r;
  assign coriolis_1 = out_h1_r;
  assign coriolis_2 = out_h2_r;
  assign gravity_1  = out_g1_r;
  assign gravity_2  = out_g2_r;
  assign overflow   = ovf_r;

  `A2RDYN_ASSERT_NXT(a_stall_holds_valids, !adv, $stable(v_r), "valid bits moved in a stall")
  `A2RDYN_ASSERT_NXT(a_last_stage_lands, adv && v_r[NST-2], v_r[NST-1], "beat lost at output")
  `A2RDYN_ASSERT_IMP(a_m22_nonneg, v_r[NST-1], !out_m22_r[OUT_W-1], "M22 came out negative")
  `A2RDYN_ASSERT_IMP(a_ovf_means_clamp, v_r[NST-1] && ovf_r, (out_h1_r == OUT_W'(Q_MAX_W)) || (out_h1_r == OUT_W'(-Q_MAX_W)) || (out_h2_r == OUT_W'(Q_MAX_W)) || (out_h2_r == OUT_W'(Q_MIN_W)), "overflow without a clamped torque")

endmodule

`default_nettype wire
